// File: design/script_token_lexer_macros.svh
// Assertion macros shared by the lexer modules.
// Each macro samples on clk and is disabled while rst is high.
`ifndef SCRIPT_TOKEN_LEXER_MACROS_SVH
`define SCRIPT_TOKEN_LEXER_MACROS_SVH

// Same-cycle implication.
`define STL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/stl_pkg.sv
// Package for the script token lexer: types, token kinds and keyword table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

  localparam int CNT_W_DEF       = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int KW_CHARS        = 8;
  localparam int KW_BITS         = 8 * KW_CHARS;
  localparam int KW_COUNT        = 8;

  // Token kinds
  localparam logic [4:0] KIND_ILLEGAL = 5'd0;
  localparam logic [4:0] KIND_EOF     = 5'd1;
  localparam logic [4:0] KIND_ASSIGN  = 5'd2;
  localparam logic [4:0] KIND_PLUS    = 5'd3;
  localparam logic [4:0] KIND_MINUS   = 5'd4;
  localparam logic [4:0] KIND_STAR    = 5'd5;
  localparam logic [4:0] KIND_SLASH   = 5'd6;
  localparam logic [4:0] KIND_LPAREN  = 5'd7;
  localparam logic [4:0] KIND_RPAREN  = 5'd8;
  localparam logic [4:0] KIND_LBRACE  = 5'd9;
  localparam logic [4:0] KIND_RBRACE  = 5'd10;
  localparam logic [4:0] KIND_SEMI    = 5'd11;
  localparam logic [4:0] KIND_COMMA   = 5'd12;
  localparam logic [4:0] KIND_STRING  = 5'd13;
  localparam logic [4:0] KIND_NUMBER  = 5'd14;
  localparam logic [4:0] KIND_IDENT   = 5'd15;
  localparam logic [4:0] KIND_KW0     = 5'd16;

  // Keywords packed first character in the low byte
  localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_0000_0074_656C,  // let
    64'h0000_0074_6E69_7270,  // print
    64'h6E6F_6974_636E_7566,  // function
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_6573_6C65,  // else
    64'h0000_0065_6C69_6877,  // while
    64'h0000_6E72_7574_6572,  // return
    64'h006B_6369_6C43_6E6F   // onClick
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd8, 4'd2, 4'd4, 4'd5, 4'd6, 4'd7
  };

  // Byte classes seen by the scanner
  typedef enum logic [2:0] {
    CLS_END, CLS_SPACE, CLS_OP, CLS_QUOTE, CLS_DIGIT, CLS_WORD, CLS_DOT, CLS_OTHER
  } cls_t;

  // Scanner modes
  typedef enum logic [1:0] {
    MODE_IDLE, MODE_NUMBER, MODE_IDENT, MODE_STRING
  } mode_t;

  // Classified byte travelling through the queue
  typedef struct packed {
    cls_t       cls;
    logic [4:0] kind;
    logic       newline;
    logic [7:0] ch;
  } item_t;

  // Match a finished word against the keyword table
  function automatic logic [4:0] word_kind(input logic [KW_BITS-1:0] wbuf,
                                           input logic [3:0] len,
                                           input logic too_long);
    logic [4:0] kind;
    kind = KIND_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!too_long && len == KW_LEN[k] && wbuf == KW_TEXT[k]) begin
        kind = KIND_KW0 + 5'(k);
      end
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

// File: design/stl_in_if.sv
// Byte input channel of the lexer: valid/ready with the text byte payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// File: design/stl_out_if.sv
// Token output channel of the lexer: valid/ready with the token payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface stl_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] start_offset;
  logic [15:0] lexeme_length;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic        last_of_run;

  modport source (output valid, output token_kind, output start_offset,
                  output lexeme_length, output line_number, output column_number,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input lexeme_length, input line_number, input column_number,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

// File: design/stl_front.sv
// Front end of the lexer: takes input beats and classifies each byte.
// Depends on stl_pkg and stl_in_if.
`timescale 1ns / 1ps
`default_nettype none

module stl_front
  import stl_pkg::*;
(
  stl_in_if.sink    text_in,
  input  logic      full,
  output logic      push,
  output item_t     push_item
);

  // Accept whenever the queue has room
  assign text_in.ready = !full;
  assign push          = text_in.valid && !full;

  // Classify the byte; end flag or zero byte ends the text
  always_comb begin
    push_item.ch      = text_in.text_byte;
    push_item.newline = (text_in.text_byte == 8'h0A);
    push_item.kind    = KIND_ILLEGAL;
    push_item.cls     = CLS_OTHER;
    if (text_in.end_of_text || text_in.text_byte == 8'h00) begin
      push_item.cls = CLS_END;
    end else begin
      case (text_in.text_byte) inside
        8'h20, 8'h09, 8'h0A, 8'h0D: push_item.cls = CLS_SPACE;
        8'h3D: begin push_item.cls = CLS_OP; push_item.kind = KIND_ASSIGN; end
        8'h2B: begin push_item.cls = CLS_OP; push_item.kind = KIND_PLUS;   end
        8'h2D: begin push_item.cls = CLS_OP; push_item.kind = KIND_MINUS;  end
        8'h2A: begin push_item.cls = CLS_OP; push_item.kind = KIND_STAR;   end
        8'h2F: begin push_item.cls = CLS_OP; push_item.kind = KIND_SLASH;  end
        8'h28: begin push_item.cls = CLS_OP; push_item.kind = KIND_LPAREN; end
        8'h29: begin push_item.cls = CLS_OP; push_item.kind = KIND_RPAREN; end
        8'h7B: begin push_item.cls = CLS_OP; push_item.kind = KIND_LBRACE; end
        8'h7D: begin push_item.cls = CLS_OP; push_item.kind = KIND_RBRACE; end
        8'h3B: begin push_item.cls = CLS_OP; push_item.kind = KIND_SEMI;   end
        8'h2C: begin push_item.cls = CLS_OP; push_item.kind = KIND_COMMA;  end
        8'h22: push_item.cls = CLS_QUOTE;
        8'h2E: push_item.cls = CLS_DOT;
        [8'h30:8'h39]: push_item.cls = CLS_DIGIT;
        [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F: push_item.cls = CLS_WORD;
        default: push_item.cls = CLS_OTHER;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/stl_queue.sv
// Short register queue of classified bytes between front and back end.
// Depends on stl_pkg and script_token_lexer_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "script_token_lexer_macros.svh"

module stl_queue
  import stl_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  item_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push_ok;
  logic          pop_ok;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];
  assign push_ok    = push && !full;
  assign pop_ok     = pop && head_valid;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_item;
    end
  end

  `STL_ASSERT_NOW(a_pop_needs_data, pop, head_valid, "pop from empty queue")
  `STL_ASSERT_NOW(a_count_bound, 1'b1, count <= FULL_CNT, "queue count overflow")
  `STL_ASSERT_NEXT(a_count_grows, push_ok && !pop_ok, count == $past(count) + 1'b1,
                   "queue count did not grow on push")

endmodule

`default_nettype wire

// File: design/stl_back.sv
// Back end of the lexer: scanner state, keyword match and token output register.
// Depends on stl_pkg, stl_out_if and script_token_lexer_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "script_token_lexer_macros.svh"

module stl_back
  import stl_pkg::*;
#(
  parameter int COUNT_WIDTH = CNT_W_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  item_t       head_item,
  output logic        pop,
  stl_out_if.source   token_out
);

  localparam int CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CNT_MAX  = '1;
  localparam logic [CW-1:0] KW_LIMIT = CW'(KW_CHARS);

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  mode_t              mode, mode_next;
  logic [CW-1:0]      offset, offset_next;
  logic [CW-1:0]      line, line_next;
  logic [CW-1:0]      col, col_next;
  logic [CW-1:0]      pstart, pstart_next;
  logic [CW-1:0]      plen, plen_next;
  logic [CW-1:0]      pline, pline_next;
  logic [CW-1:0]      pcol, pcol_next;
  logic [KW_BITS-1:0] wbuf, wbuf_next;
  logic               too_long, too_long_next;

  logic               out_valid;
  logic [4:0]         out_kind;
  logic [15:0]        out_start;
  logic [15:0]        out_len;
  logic [15:0]        out_line;
  logic [15:0]        out_col;
  logic               out_last;

  logic               go;
  logic               emit;
  logic               flush;
  logic               adv;
  logic               restart;
  logic               idle_emits;
  logic [4:0]         pend_kind;
  logic [4:0]         tok_kind;
  logic [CW-1:0]      tok_start;
  logic [CW-1:0]      tok_len;
  logic [CW-1:0]      tok_line;
  logic [CW-1:0]      tok_col;
  logic               tok_last;

  // Work on the head beat while the output register can take a token
  assign go = head_valid && (!out_valid || token_out.ready);

  // Whether the byte, seen from idle, produces a token of its own
  assign idle_emits = head_item.cls inside {CLS_END, CLS_OP, CLS_DOT, CLS_OTHER};

  // Kind of the pending token
  always_comb begin
    case (mode)
      MODE_NUMBER: pend_kind = KIND_NUMBER;
      MODE_STRING: pend_kind = KIND_STRING;
      MODE_IDENT:  pend_kind = word_kind(wbuf, plen[3:0], too_long || plen > KW_LIMIT);
      default:     pend_kind = KIND_ILLEGAL;
    endcase
  end

  // Next scanner state and token to load
  always_comb begin
    mode_next     = mode;
    offset_next   = offset;
    line_next     = line;
    col_next      = col;
    pstart_next   = pstart;
    plen_next     = plen;
    pline_next    = pline;
    pcol_next     = pcol;
    wbuf_next     = wbuf;
    too_long_next = too_long;
    pop       = 1'b0;
    emit      = 1'b0;
    flush     = 1'b0;
    adv       = 1'b0;
    restart   = 1'b0;
    tok_kind  = KIND_ILLEGAL;
    tok_start = offset;
    tok_len   = CW'(1);
    tok_line  = line;
    tok_col   = col;
    tok_last  = 1'b1;

    if (go) begin
      case (mode)
        MODE_NUMBER: begin
          if (head_item.cls inside {CLS_DIGIT, CLS_DOT}) begin
            plen_next = sat_inc(plen);
            pop = 1'b1;
            adv = 1'b1;
          end else begin
            flush = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (head_item.cls inside {CLS_DIGIT, CLS_WORD}) begin
            for (int i = 0; i < KW_CHARS; i++) begin
              if (plen == CW'(i)) begin
                wbuf_next[8*i +: 8] = head_item.ch;
              end
            end
            if (plen >= KW_LIMIT) begin
              too_long_next = 1'b1;
            end
            plen_next = sat_inc(plen);
            pop = 1'b1;
            adv = 1'b1;
          end else begin
            flush = 1'b1;
          end
        end
        MODE_STRING: begin
          if (head_item.cls == CLS_END) begin
            flush = 1'b1;
          end else begin
            if (head_item.cls == CLS_QUOTE) begin
              flush = 1'b1;
            end else begin
              plen_next = sat_inc(plen);
            end
            pop = 1'b1;
            adv = 1'b1;
          end
        end
        default: begin
          pop = 1'b1;
          case (head_item.cls)
            CLS_END: begin
              emit     = 1'b1;
              tok_kind = KIND_EOF;
              tok_len  = '0;
              restart  = 1'b1;
            end
            CLS_SPACE: adv = 1'b1;
            CLS_OP: begin
              emit     = 1'b1;
              tok_kind = head_item.kind;
              adv      = 1'b1;
            end
            CLS_QUOTE: begin
              mode_next     = MODE_STRING;
              pstart_next   = sat_inc(offset);
              plen_next     = '0;
              pline_next    = line;
              pcol_next     = col;
              wbuf_next     = '0;
              too_long_next = 1'b0;
              adv           = 1'b1;
            end
            CLS_DIGIT: begin
              mode_next     = MODE_NUMBER;
              pstart_next   = offset;
              plen_next     = CW'(1);
              pline_next    = line;
              pcol_next     = col;
              wbuf_next     = '0;
              too_long_next = 1'b0;
              adv           = 1'b1;
            end
            CLS_WORD: begin
              mode_next     = MODE_IDENT;
              pstart_next   = offset;
              plen_next     = CW'(1);
              pline_next    = line;
              pcol_next     = col;
              wbuf_next     = KW_BITS'(head_item.ch);
              too_long_next = 1'b0;
              adv           = 1'b1;
            end
            default: begin
              emit     = 1'b1;
              tok_kind = KIND_ILLEGAL;
              adv      = 1'b1;
            end
          endcase
        end
      endcase
    end

    // Emit the pending token and drop back to idle
    if (flush) begin
      emit      = 1'b1;
      tok_kind  = pend_kind;
      tok_start = pstart;
      tok_len   = plen;
      tok_line  = pline;
      tok_col   = pcol;
      tok_last  = !idle_emits;
      mode_next = MODE_IDLE;
    end

    // Advance the text position past the byte
    if (adv) begin
      offset_next = sat_inc(offset);
      if (head_item.newline) begin
        line_next = sat_inc(line);
        col_next  = CW'(1);
      end else begin
        col_next  = sat_inc(col);
      end
    end

    // End of text: back to the reset state
    if (restart) begin
      mode_next     = MODE_IDLE;
      offset_next   = '0;
      line_next     = CW'(1);
      col_next      = CW'(1);
      pstart_next   = '0;
      plen_next     = '0;
      pline_next    = CW'(1);
      pcol_next     = CW'(1);
      wbuf_next     = '0;
      too_long_next = 1'b0;
    end
  end

  // Scanner state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      offset    <= '0;
      line      <= CW'(1);
      col       <= CW'(1);
      pstart    <= '0;
      plen      <= '0;
      pline     <= CW'(1);
      pcol      <= CW'(1);
      wbuf      <= '0;
      too_long  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mode      <= mode_next;
      offset    <= offset_next;
      line      <= line_next;
      col       <= col_next;
      pstart    <= pstart_next;
      plen      <= plen_next;
      pline     <= pline_next;
      pcol      <= pcol_next;
      wbuf      <= wbuf_next;
      too_long  <= too_long_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (token_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the token beat
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind  <= tok_kind;
      out_start <= 16'(tok_start);
      out_len   <= 16'(tok_len);
      out_line  <= 16'(tok_line);
      out_col   <= 16'(tok_col);
      out_last  <= tok_last;
    end
  end

  assign token_out.valid         = out_valid;
  assign token_out.token_kind    = out_kind;
  assign token_out.start_offset  = out_start;
  assign token_out.lexeme_length = out_len;
  assign token_out.line_number   = out_line;
  assign token_out.column_number = out_col;
  assign token_out.last_of_run   = out_last;

  `STL_ASSERT_NEXT(a_flush_to_idle, flush, mode == MODE_IDLE,
                   "scanner not idle after flushing a token")
  `STL_ASSERT_NEXT(a_eof_restarts, restart,
                   offset == '0 && line == CW'(1) && col == CW'(1) && mode == MODE_IDLE,
                   "position not cleared after end of text")
  `STL_ASSERT_NEXT(a_emit_loads, emit, out_valid, "token lost at output register")

endmodule

`default_nettype wire

// File: design/script_token_lexer.sv
// Script token lexer top level: front classifier, byte queue, scanner back end.
// A token is registered at the output after its byte passes the byte queue.
// One byte per cycle; a byte that closes a number or identifier, or ends the
// text in a pending token, waits for that token; a held token stalls the flow.
// Reset (synchronous rst): queue empty, output idle, position line 1 column 1.
`timescale 1ns / 1ps
`default_nettype none

module script_token_lexer
  import stl_pkg::*;
#(
  parameter int COUNT_WIDTH = CNT_W_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  stl_in_if.sink      text_in,
  stl_out_if.source   token_out
);

  logic  push;
  logic  full;
  logic  pop;
  logic  head_valid;
  item_t push_item;
  item_t head_item;

  stl_front u_front (
    .text_in   (text_in),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  stl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  stl_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .token_out  (token_out)
  );

endmodule

`default_nettype wire
